FILE: hdl/multilevel_queue_slot_scheduler_unit_defines.svh
// Assertion macros shared by the scheduler RTL.
`ifndef MULTILEVEL_QUEUE_SLOT_SCHEDULER_UNIT_DEFINES_SVH
`define MULTILEVEL_QUEUE_SLOT_SCHEDULER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MLQS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MLQS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: hdl/mlqs_pkg.sv
// Shared constants for the multilevel queue slot scheduler.
package mlqs_pkg;

    // default configuration
    localparam int DEF_NUM_LEVELS  = 16;
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_ID_BITS     = 8;

    // fixed port widths
    localparam int ID_W     = 8;
    localparam int PRIO_W   = 4;
    localparam int STATUS_W = 2;

    // request codes
    localparam logic REQ_ADD = 1'b0;
    localparam logic REQ_GET = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

FILE: hdl/mlqs_lvl_ram.sv
// Per-level pointer/count record memory; unwritten entries read as zero.
module mlqs_lvl_ram #(
    parameter int DEPTH = mlqs_pkg::DEF_NUM_LEVELS,
    parameter int WIDTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    import mlqs_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rdata_reg;

    // valid bits stand in for the all-zero reset of the records
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= valid_reg[raddr] ? mem[raddr] : '0;
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/mlqs_id_ram.sv
// Process id store, one region of QUEUE_DEPTH entries per level.
module mlqs_id_ram #(
    parameter int DEPTH = mlqs_pkg::DEF_NUM_LEVELS * mlqs_pkg::DEF_QUEUE_DEPTH,
    parameter int WIDTH = mlqs_pkg::DEF_ID_BITS,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    import mlqs_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/multilevel_queue_slot_scheduler_unit.sv
// Top level of the multilevel queue slot scheduler: sequencer, level scan, result register.
//
// Channel   Direction  Handshake                 Payload
// command   in         start & !busy accepts     req_type, proc_id, priority_req
// result    out        done, one cycle, no stall granted_id, granted, status
//
// Add: busy for one cycle, result after the S_ADD state and the done register; a level out of
//   range answers in the cycle after the accept with no busy time.
// Get: through S_POP and S_GRANT to the result when the current level still has budget
//   and ids; otherwise the scan unit walks one level per cycle from the start level
//   before the pop. The scan walk sets the worst case.
// Record and id memories have registered reads, so every pop reads the record
//   first, then the id.
// Reset (rst_n, async low) clears all levels and the scan state; the id store
//   needs no clearing pass. done is a one-cycle strobe; the receiver cannot stall.
`include "multilevel_queue_slot_scheduler_unit_defines.svh"

module multilevel_queue_slot_scheduler_unit #(
    parameter int NUM_LEVELS  = mlqs_pkg::DEF_NUM_LEVELS,
    parameter int QUEUE_DEPTH = mlqs_pkg::DEF_QUEUE_DEPTH,
    parameter int ID_BITS     = mlqs_pkg::DEF_ID_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          req_type,
    input  logic [mlqs_pkg::ID_W-1:0]     proc_id,
    input  logic [mlqs_pkg::PRIO_W-1:0]   priority_req,
    output logic                          done,
    output logic [mlqs_pkg::ID_W-1:0]     granted_id,
    output logic                          granted,
    output logic [mlqs_pkg::STATUS_W-1:0] status
);
    import mlqs_pkg::*;

    localparam int LVL_W  = $clog2(NUM_LEVELS);
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_W = $clog2(NUM_LEVELS + 1);
    localparam int ID_AW  = $clog2(NUM_LEVELS * QUEUE_DEPTH);
    localparam int REC_W  = 2 * PTR_W + CNT_W;

    typedef struct packed {
        logic [PTR_W-1:0] head;
        logic [PTR_W-1:0] tail;
        logic [CNT_W-1:0] count;
    } lvl_rec_t;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ADD   = 5'b00010,
        S_SCAN  = 5'b00100,
        S_POP   = 5'b01000,
        S_GRANT = 5'b10000
    } state_t;

    function automatic logic [LVL_W-1:0] lvl_inc(input logic [LVL_W-1:0] v);
        logic [LVL_W-1:0] r;
        r = (v == LVL_W'(NUM_LEVELS - 1)) ? '0 : v + 1'b1;
        return r;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] v);
        logic [PTR_W-1:0] r;
        r = (v == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : v + 1'b1;
        return r;
    endfunction

    // control state
    state_t                  state_reg, state_next;
    logic [LVL_W-1:0]        current_level_reg, current_level_next;
    logic [SLOT_W-1:0]       slots_used_reg, slots_used_next;
    logic                    level_active_reg, level_active_next;
    logic [NUM_LEVELS-1:0]   nonempty_reg, nonempty_next;
    logic [LVL_W-1:0]        scan_reg, scan_next;
    logic [LVL_W-1:0]        scan_start_reg, scan_start_next;
    logic [LVL_W-1:0]        scan_cnt_reg, scan_cnt_next;
    logic                    done_reg, done_next;

    // payload
    logic [LVL_W-1:0]        lvl_reg, lvl_next;
    logic [ID_AW-1:0]        base_reg, base_next;
    logic [ID_BITS-1:0]      id_reg, id_next;
    logic [ID_W-1:0]         granted_id_reg, granted_id_next;
    logic                    granted_reg, granted_next;
    logic [STATUS_W-1:0]     status_reg, status_next;

    // memory ports
    logic                    lvl_issue;
    logic [LVL_W-1:0]        lvl_sel;
    logic                    lvl_we;
    lvl_rec_t                lvl_wdata;
    lvl_rec_t                lvl_rdata;
    logic                    id_we;
    logic [ID_AW-1:0]        id_waddr;
    logic                    id_re;
    logic [ID_AW-1:0]        id_raddr;
    logic [ID_BITS-1:0]      id_rdata;

    logic                    budget_ok;

    mlqs_lvl_ram #(
        .DEPTH (NUM_LEVELS),
        .WIDTH (REC_W)
    ) u_lvl_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (lvl_we),
        .waddr (lvl_reg),
        .wdata (lvl_wdata),
        .re    (lvl_issue),
        .raddr (lvl_sel),
        .rdata (lvl_rdata)
    );

    mlqs_id_ram #(
        .DEPTH (NUM_LEVELS * QUEUE_DEPTH),
        .WIDTH (ID_BITS)
    ) u_id_ram (
        .clk   (clk),
        .we    (id_we),
        .waddr (id_waddr),
        .wdata (id_reg),
        .re    (id_re),
        .raddr (id_raddr),
        .rdata (id_rdata)
    );

    // current level may keep serving while picks stay under NUM_LEVELS - level
    assign budget_ok = (32'(slots_used_reg) + 32'(current_level_reg)) < 32'(NUM_LEVELS);

    // region base of the level whose record is being fetched
    assign base_next = ID_AW'(32'(lvl_sel) * QUEUE_DEPTH);

    always_comb
    begin
        state_next         = state_reg;
        current_level_next = current_level_reg;
        slots_used_next    = slots_used_reg;
        level_active_next  = level_active_reg;
        nonempty_next      = nonempty_reg;
        scan_next          = scan_reg;
        scan_start_next    = scan_start_reg;
        scan_cnt_next      = scan_cnt_reg;
        done_next          = 1'b0;
        id_next            = id_reg;
        granted_id_next    = granted_id_reg;
        granted_next       = granted_reg;
        status_next        = status_reg;
        lvl_issue          = 1'b0;
        lvl_sel            = current_level_reg;
        lvl_we             = 1'b0;
        lvl_wdata          = lvl_rdata;
        id_we              = 1'b0;
        id_waddr           = base_reg + ID_AW'(lvl_rdata.tail);
        id_re              = 1'b0;
        id_raddr           = base_reg + ID_AW'(lvl_rdata.head);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (req_type == REQ_ADD)
                    begin
                        if (32'(priority_req) >= 32'(NUM_LEVELS))
                        begin
                            // level out of range: reject, nothing changes
                            done_next       = 1'b1;
                            granted_id_next = '0;
                            granted_next    = 1'b0;
                            status_next     = ST_FULL;
                        end
                        else
                        begin
                            lvl_sel    = LVL_W'(priority_req);
                            lvl_issue  = 1'b1;
                            id_next    = ID_BITS'(proc_id);
                            state_next = S_ADD;
                        end
                    end
                    else if (level_active_reg && budget_ok
                             && nonempty_reg[current_level_reg])
                    begin
                        slots_used_next = slots_used_reg + 1'b1;
                        lvl_sel         = current_level_reg;
                        lvl_issue       = 1'b1;
                        state_next      = S_POP;
                    end
                    else
                    begin
                        // first get after reset or an empty answer scans from the level itself
                        scan_next       = level_active_reg ? lvl_inc(current_level_reg)
                                                           : current_level_reg;
                        scan_start_next = scan_next;
                        scan_cnt_next   = '0;
                        state_next      = S_SCAN;
                    end
                end
            end

            S_ADD:
            begin
                done_next       = 1'b1;
                granted_id_next = '0;
                granted_next    = 1'b0;
                state_next      = S_IDLE;
                if (32'(lvl_rdata.count) >= 32'(QUEUE_DEPTH))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next            = ST_OK;
                    id_we                  = 1'b1;
                    lvl_we                 = 1'b1;
                    lvl_wdata.tail         = ptr_inc(lvl_rdata.tail);
                    lvl_wdata.count        = lvl_rdata.count + 1'b1;
                    nonempty_next[lvl_reg] = 1'b1;
                end
            end

            S_SCAN:
            begin
                if (nonempty_reg[scan_reg])
                begin
                    current_level_next = scan_reg;
                    slots_used_next    = SLOT_W'(1);
                    level_active_next  = 1'b1;
                    lvl_sel            = scan_reg;
                    lvl_issue          = 1'b1;
                    state_next         = S_POP;
                end
                else if (scan_cnt_reg == LVL_W'(NUM_LEVELS - 1))
                begin
                    // every level empty
                    current_level_next = scan_start_reg;
                    slots_used_next    = '0;
                    level_active_next  = 1'b0;
                    done_next          = 1'b1;
                    granted_id_next    = '0;
                    granted_next       = 1'b0;
                    status_next        = ST_EMPTY;
                    state_next         = S_IDLE;
                end
                else
                begin
                    scan_next     = lvl_inc(scan_reg);
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
            end

            S_POP:
            begin
                id_re           = 1'b1;
                lvl_we          = 1'b1;
                lvl_wdata.head  = ptr_inc(lvl_rdata.head);
                lvl_wdata.count = lvl_rdata.count - 1'b1;
                if (lvl_rdata.count == CNT_W'(1))
                begin
                    nonempty_next[lvl_reg] = 1'b0;
                end
                state_next = S_GRANT;
            end

            S_GRANT:
            begin
                done_next       = 1'b1;
                granted_id_next = ID_W'(id_rdata);
                granted_next    = 1'b1;
                status_next     = ST_OK;
                state_next      = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign lvl_next = lvl_issue ? lvl_sel : lvl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            current_level_reg <= '0;
            slots_used_reg    <= '0;
            level_active_reg  <= 1'b0;
            nonempty_reg      <= '0;
            scan_reg          <= '0;
            scan_start_reg    <= '0;
            scan_cnt_reg      <= '0;
            done_reg          <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            current_level_reg <= current_level_next;
            slots_used_reg    <= slots_used_next;
            level_active_reg  <= level_active_next;
            nonempty_reg      <= nonempty_next;
            scan_reg          <= scan_next;
            scan_start_reg    <= scan_start_next;
            scan_cnt_reg      <= scan_cnt_next;
            done_reg          <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg        <= lvl_next;
        if (lvl_issue)
        begin
            base_reg <= base_next;
        end
        id_reg         <= id_next;
        granted_id_reg <= granted_id_next;
        granted_reg    <= granted_next;
        status_reg     <= status_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign granted_id = granted_id_reg;
    assign granted    = granted_reg;
    assign status     = status_reg;

    // a result beat only appears once the sequencer is back in idle
    `MLQS_ASSERT_NOW(a_done_when_idle, done_reg, state_reg == S_IDLE)
    // a pop is always followed by the grant state next cycle, with the block still busy
    `MLQS_ASSERT_NEXT(a_pop_then_grant, state_reg == S_POP, state_reg == S_GRANT && busy)
    // a grant always carries ok status
    `MLQS_ASSERT_NOW(a_grant_ok, done_reg && granted_reg, status_reg == ST_OK)
    // serving level never exceeds its budget
    `MLQS_ASSERT_NOW(a_budget,
        level_active_reg,
        (32'(slots_used_reg) + 32'(current_level_reg)) <= 32'(NUM_LEVELS))

endmodule

FILE: tb/multilevel_queue_slot_scheduler_unit_tb.sv
// Self-checking testbench for the multilevel queue slot scheduler: random and directed beats.
`timescale 1ns / 100ps

module multilevel_queue_slot_scheduler_unit_tb;
    import mlqs_pkg::*;

    localparam int LEVELS     = DEF_NUM_LEVELS;
    localparam int DEPTH      = DEF_QUEUE_DEPTH;
    localparam int IDB        = DEF_ID_BITS;
    localparam int LVL_W      = $clog2(LEVELS);
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int RAND_BEATS = 900;
    // Worst get is a full level walk plus the pop and grant; drain margin after the last result.
    localparam int DRAIN_CYC  = 40;
    // Sized for the slowest beat (full level walk) plus the longest sender gap, ~950 beats.
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic              req;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } sched_cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]     gid;
        logic                granted;
        logic [STATUS_W-1:0] status;
    } sched_res_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                req_type = REQ_ADD;
    logic [ID_W-1:0]     proc_id = '0;
    logic [PRIO_W-1:0]   priority_req = '0;
    logic                busy;
    logic                done;
    logic [ID_W-1:0]     granted_id;
    logic                granted;
    logic [STATUS_W-1:0] status;

    multilevel_queue_slot_scheduler_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .proc_id      (proc_id),
        .priority_req (priority_req),
        .done         (done),
        .granted_id   (granted_id),
        .granted      (granted),
        .status       (status)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Scheduler shadow state, updated once per accepted command beat.
    // ------------------------------------------------------------------
    logic [IDB-1:0]   lvl_mem [LEVELS][DEPTH];
    logic [PTR_W-1:0] lvl_head [LEVELS];
    logic [PTR_W-1:0] lvl_tail [LEVELS];
    logic [PTR_W:0]   lvl_count [LEVELS];
    logic [LVL_W-1:0] serve_level;
    logic [LVL_W:0]   picks_used;
    logic             serving;

    sched_cmd_t cmd_backlog [$];
    sched_res_t expected_grants [$];
    sched_cmd_t cur_cmd;
    int         gap_left = 0;
    int         fast_left = 0;
    int         fail_count = 0;
    int         cycle_count = 0;

    // Dequeue the head id of one level.
    function automatic logic [IDB-1:0] pop_level_id(int lvl);
        logic [IDB-1:0] id;
        id = lvl_mem[lvl][lvl_head[lvl]];
        lvl_head[lvl] = PTR_W'((int'(lvl_head[lvl]) + 1) % DEPTH);
        lvl_count[lvl] = lvl_count[lvl] - 1'b1;
        return id;
    endfunction

    // Apply one command to the shadow state and return the result it must produce.
    function automatic sched_res_t serve_request(sched_cmd_t c);
        sched_res_t r;
        int         lvl;
        int         budget;
        int         scan_from;
        int         k;
        r = '{gid: '0, granted: 1'b0, status: ST_OK};
        lvl = int'(c.prio);
        if (c.req == REQ_ADD)
        begin
            // out-of-range level or full level: rejected, nothing changes
            if (lvl >= LEVELS || int'(lvl_count[lvl]) >= DEPTH)
            begin
                r.status = ST_FULL;
                return r;
            end
            lvl_mem[lvl][lvl_tail[lvl]] = IDB'(c.id);
            lvl_tail[lvl] = PTR_W'((int'(lvl_tail[lvl]) + 1) % DEPTH);
            lvl_count[lvl] = lvl_count[lvl] + 1'b1;
            return r;
        end
        // get: keep serving this level while budget and ids remain
        if (serving)
        begin
            budget = LEVELS - int'(serve_level);
            if (int'(picks_used) < budget && lvl_count[serve_level] != 0)
            begin
                picks_used = picks_used + 1'b1;
                r.gid = ID_W'(pop_level_id(int'(serve_level)));
                r.granted = 1'b1;
                return r;
            end
            scan_from = (int'(serve_level) + 1) % LEVELS;
        end
        else
        begin
            // first get after reset, or after an all-empty answer: scan from here
            scan_from = int'(serve_level);
        end
        for (int i = 0; i < LEVELS; i++)
        begin
            k = (scan_from + i) % LEVELS;
            if (lvl_count[k] != 0)
            begin
                serve_level = LVL_W'(k);
                picks_used = (LVL_W + 1)'(1);
                serving = 1'b1;
                r.gid = ID_W'(pop_level_id(k));
                r.granted = 1'b1;
                return r;
            end
        end
        // every level empty
        serve_level = LVL_W'(scan_from);
        picks_used = '0;
        serving = 1'b0;
        r.status = ST_EMPTY;
        return r;
    endfunction

    // Sender idle time after a beat: mostly none or short, a few long,
    // with occasional stretches of back-to-back beats.
    function automatic int pick_gap();
        int r;
        if (fast_left > 0)
        begin
            fast_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            fast_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Levels 0, 1, 2 and the lowest two see most traffic so that full levels,
    // budget exhaustion and the scan wrap come up often.
    function automatic logic [PRIO_W-1:0] pick_level();
        if ($urandom_range(0, 3) == 0) return PRIO_W'($urandom_range(0, (1 << PRIO_W) - 1));
        case ($urandom_range(0, 4))
            0: return PRIO_W'(0);
            1: return PRIO_W'(1);
            2: return PRIO_W'(2);
            3: return PRIO_W'(LEVELS - 2);
            default: return PRIO_W'(LEVELS - 1);
        endcase
    endfunction

    task automatic queue_cmd(logic req, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio);
        sched_cmd_t c;
        c.req = req;
        c.id = id;
        c.prio = prio;
        cmd_backlog.push_back(c);
    endtask

    // ------------------------------------------------------------------
    // Driver: a beat is taken at an edge with start high and busy low.
    // The shadow state advances at that same edge, in acceptance order.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            for (int l = 0; l < LEVELS; l++)
            begin
                lvl_head[l] = '0;
                lvl_tail[l] = '0;
                lvl_count[l] = '0;
            end
            serve_level = '0;
            picks_used = '0;
            serving = 1'b0;
        end
        else if (!(start && busy))
        begin
            if (start)
            begin
                expected_grants.push_back(serve_request(cur_cmd));
                gap_left = pick_gap();
            end
            // one assignment to start per edge: held high across back-to-back beats
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (cmd_backlog.size() > 0)
            begin
                cur_cmd = cmd_backlog.pop_front();
                req_type <= cur_cmd.req;
                proc_id <= cur_cmd.id;
                priority_req <= cur_cmd.prio;
                start <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: done is a one-cycle strobe, no backpressure possible.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        sched_res_t exp_r;
        if (rst_n && done)
        begin
            if (expected_grants.size() == 0)
            begin
                $display("%0t: unexpected result beat id=%0h granted=%0b status=%0d",
                         $time, granted_id, granted, status);
                fail_count++;
            end
            else
            begin
                exp_r = expected_grants.pop_front();
                if (granted_id !== exp_r.gid)
                begin
                    $display("%0t: granted_id expected %0h actual %0h",
                             $time, exp_r.gid, granted_id);
                    fail_count++;
                end
                if (granted !== exp_r.granted)
                begin
                    $display("%0t: granted expected %0b actual %0b",
                             $time, exp_r.granted, granted);
                    fail_count++;
                end
                if (status !== exp_r.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_r.status, status);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still expected", $time, expected_grants.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial
    begin
        int seg;
        int n;
        int lvl;

        // Directed: get with everything empty (scan starts at level 0 after reset)
        queue_cmd(REQ_GET, ID_W'(8'hA5), PRIO_W'(4'hF));
        // extreme ids on the lowest level, whose budget is a single pick
        queue_cmd(REQ_ADD, ID_W'(0), PRIO_W'(LEVELS - 1));
        queue_cmd(REQ_ADD, ID_W'(8'hFF), PRIO_W'(LEVELS - 1));
        queue_cmd(REQ_GET, ID_W'(8'hFF), PRIO_W'(0));
        // budget spent: scan wraps past the last level and comes back to it
        queue_cmd(REQ_GET, ID_W'(0), PRIO_W'(0));
        // fill level 0 to the brim, then one add too many
        for (int i = 0; i <= DEPTH; i++)
            queue_cmd(REQ_ADD, ID_W'($urandom_range(0, 255)), PRIO_W'(0));

        // Random segments: mixed traffic, fill bursts, drain bursts and noise.
        n = 0;
        while (n < RAND_BEATS)
        begin
            seg = $urandom_range(0, 99);
            if (seg < 50)
            begin
                repeat ($urandom_range(10, 30))
                begin
                    queue_cmd(($urandom_range(0, 99) < 55) ? REQ_ADD : REQ_GET,
                              ID_W'($urandom_range(0, 255)), pick_level());
                    n++;
                end
            end
            else if (seg < 70)
            begin
                lvl = int'(pick_level());
                repeat ($urandom_range(10, 20))
                begin
                    queue_cmd(REQ_ADD, ID_W'($urandom_range(0, 255)), PRIO_W'(lvl));
                    n++;
                end
            end
            else if (seg < 90)
            begin
                repeat ($urandom_range(10, 30))
                begin
                    queue_cmd(REQ_GET, ID_W'($urandom_range(0, 255)),
                              PRIO_W'($urandom_range(0, (1 << PRIO_W) - 1)));
                    n++;
                end
            end
            else
            begin
                repeat ($urandom_range(5, 15))
                begin
                    queue_cmd(1'($urandom_range(0, 1)), ID_W'($urandom_range(0, 255)),
                              PRIO_W'($urandom_range(0, (1 << PRIO_W) - 1)));
                    n++;
                end
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // all beats taken and every result seen, then let the block settle
        while (cmd_backlog.size() != 0 || start || expected_grants.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        if (fail_count == 0 && expected_grants.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/mlqs_pkg.sv
hdl/mlqs_lvl_ram.sv
hdl/mlqs_id_ram.sv
hdl/multilevel_queue_slot_scheduler_unit.sv
tb/multilevel_queue_slot_scheduler_unit_tb.sv
